// ----- rtl/core/bdeq_pkg.sv -----
// Package: request/result types, request codes, status codes and queue constants for the deque.
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/bdeq_front.sv -----
// Front end: accepts transactions, decodes the request code and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_front import bdeq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_req i_req,
    output logic      o_busy,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_take
);

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wptr, n_wptr;
    logic [CQ_AW-1:0] r_rptr, n_rptr;
    logic [CQ_CW-1:0] r_cnt, n_cnt;

    t_cmd dec_cmd;
    logic dec_ok;
    logic push;
    logic pop;

    always_comb begin
        dec_cmd.value = i_req.value;
        dec_cmd.op    = OP_PUSH_FRONT;
        dec_ok        = 1'b1;
        unique case (i_req.req_type)
            REQ_PUSH_FRONT: dec_cmd.op = OP_PUSH_FRONT;
            REQ_PUSH_BACK:  dec_cmd.op = OP_PUSH_BACK;
            REQ_POP_FRONT:  dec_cmd.op = OP_POP_FRONT;
            REQ_POP_BACK:   dec_cmd.op = OP_POP_BACK;
            REQ_LIST:       dec_cmd.op = OP_LIST;
            default:        dec_ok     = 1'b0;
        endcase
    end

    assign o_busy      = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];

    assign push = i_start && !o_busy && dec_ok;
    assign pop  = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_wptr + CQ_AW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_rptr + CQ_AW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CQ_CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= dec_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bdeq_back.sv -----
// Back end: ring store, front index and entry count; executes commands and drives results.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_back import bdeq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_take,
    output logic      o_strobe,
    output t_result   o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state             r_state;
    logic [IW-1:0]      r_front;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_valid;
    logic               r_from_mem;
    logic [1:0]         r_status;
    logic               r_last;
    logic signed [31:0] r_rd_data;
    logic signed [31:0] mem [DEPTH];

    logic          full;
    logic          empty;
    logic          is_push;
    logic          is_pop;
    logic [IW-1:0] dec_front;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          list_last;

    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign is_push    = (i_cmd.op == OP_PUSH_FRONT) || (i_cmd.op == OP_PUSH_BACK);
    assign is_pop     = (i_cmd.op == OP_POP_FRONT) || (i_cmd.op == OP_POP_BACK);
    assign dec_front  = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);
    assign list_last  = (r_idx == r_count - CW'(1));

    assign wr_en   = o_cmd_take && is_push && !full;
    assign wr_addr = (i_cmd.op == OP_PUSH_FRONT) ? dec_front : ring(r_front, r_count);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_front;
        if (r_state == S_LIST) begin
            rd_en   = 1'b1;
            rd_addr = ring(r_front, r_idx);
        end else if (o_cmd_take && !empty) begin
            priority if (i_cmd.op == OP_POP_BACK) begin
                rd_en   = 1'b1;
                rd_addr = ring(r_front, r_count - CW'(1));
            end else if (i_cmd.op == OP_POP_FRONT || i_cmd.op == OP_LIST) begin
                rd_en   = 1'b1;
                rd_addr = r_front;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_front    <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_valid    <= 1'b0;
            r_from_mem <= 1'b0;
            r_status   <= ST_OK;
            r_last     <= 1'b0;
        end else begin
            r_valid    <= 1'b0;
            r_from_mem <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_valid <= 1'b1;
                        r_last  <= 1'b1;
                        if (is_push) begin
                            if (full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_OK;
                                r_count  <= r_count + CW'(1);
                                if (i_cmd.op == OP_PUSH_FRONT) begin
                                    r_front <= dec_front;
                                end
                            end
                        end else if (is_pop) begin
                            if (empty) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_status   <= ST_OK;
                                r_from_mem <= 1'b1;
                                r_count    <= r_count - CW'(1);
                                if (i_cmd.op == OP_POP_FRONT) begin
                                    r_front <= ring(r_front, CW'(1));
                                end
                            end
                        end else begin
                            if (empty) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_status   <= ST_OK;
                                r_from_mem <= 1'b1;
                                r_last     <= (r_count == CW'(1));
                                if (r_count != CW'(1)) begin
                                    r_idx   <= CW'(1);
                                    r_state <= S_LIST;
                                end
                            end
                        end
                    end
                end
                S_LIST: begin
                    r_valid    <= 1'b1;
                    r_from_mem <= 1'b1;
                    r_status   <= ST_OK;
                    r_last     <= list_last;
                    r_idx      <= r_idx + CW'(1);
                    if (list_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe        = r_valid;
    assign o_result.status = r_status;
    assign o_result.data   = r_from_mem ? r_rd_data : '0;
    assign o_result.last   = r_last;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_double_ended_queue.sv -----
// Top level: bounded double-ended queue of signed 32-bit words in a ring store.
//
// Requests enter on start/i_req and are taken at an edge where start is high and
// busy is low. Codes: push front, push back, pop front, pop back, list all;
// unused codes are dropped with no result. Results leave on o_result, each
// valid for exactly one cycle while o_strobe is high; the receiver cannot stall.
// A decoder feeds a two-entry command queue; the executor behind it owns the
// ring store (one write or one registered read per cycle).
// The first result of a transaction is registered in the executor once its command
// leaves the command queue; a list still in progress can hold that command back.
// The executor takes a new command after each push or pop; a list holds it until
// every held entry is read out (an empty one gives a single result). busy rises
// only while the command queue holds two commands.
// Reset (i_rst_n low, synchronous) empties the queue and clears the front index;
// the store contents are left as they are and only held entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue import bdeq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_strobe,
    output t_result   o_result
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    bdeq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    bdeq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
